>>> rtl/core/lcs_pkg.sv
// Package for the longest common substring block.
// Holds the item types, opcodes, size constants and the controller states.
// Depends on nothing; the top level, the checker and the bench files import it.
package lcs_pkg;

  localparam int unsigned LCS_MAX_LEN = 32;
  localparam int unsigned LCS_FIELD_W = 6;

  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_COMPUTE       = 2'd2,
    OP_UNUSED        = 2'd3
  } lcs_opcode_t;

  typedef struct packed {
    lcs_opcode_t opcode;
    logic [7:0]  symbol;
  } lcs_in_t;

  typedef struct packed {
    logic [7:0]             out_symbol;
    logic [LCS_FIELD_W-1:0] match_length;
    logic [LCS_FIELD_W-1:0] end_in_first;
    logic [LCS_FIELD_W-1:0] end_in_second;
    logic                   is_empty;
    logic                   was_truncated;
    logic                   is_last;
  } lcs_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_CELL,
    S_DRAIN,
    S_EMIT_RD,
    S_EMIT_PUT
  } lcs_state_t;

endpackage

>>> rtl/core/lcs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Used for both strings and the run-length row; no package dependency.
module lcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/longest_common_substring_top.sv
// Longest common substring block, top level; uses lcs_pkg and lcs_ram.
// A load item is taken without a stall. A compute item stalls the input through the table
// walk (per row, a fetch of the first-string byte and a step per cell; a drain step to
// retire the last cell), then a read and a put per result item, plus any output stalls.
// With either string empty the walk is skipped and the single result is put directly.
// Synchronous reset clears state, lengths, overflow, cell valid, best match and out_valid; memories keep data.
module longest_common_substring_top #(
  parameter int unsigned MAX_LEN = lcs_pkg::LCS_MAX_LEN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lcs_pkg::lcs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lcs_pkg::lcs_out_t out_data
);

  import lcs_pkg::*;

  // AW addresses a string memory; LW holds a length, a column or a run value
  // (up to MAX_LEN) and addresses the run row, which has MAX_LEN+1 entries.
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  // Controller state and counters.
  lcs_state_t     state_r, state_nxt;
  logic [LW-1:0]  first_len_r, first_len_nxt;
  logic [LW-1:0]  second_len_r, second_len_nxt;
  logic           overflow_r, overflow_nxt;
  logic [LW-1:0]  row_r, row_nxt;
  logic [LW-1:0]  col_r, col_nxt;
  logic [LW-1:0]  k_r, k_nxt;

  // Cell stage: one cell is in flight between the memory read and write-back.
  logic           cv_r, cv_nxt;
  logic           cfirst_r, cfirst_nxt;
  logic [LW-1:0]  ccol_r, ccol_nxt;
  logic [LW-1:0]  crow_r, crow_nxt;
  logic [LW-1:0]  diag_r, diag_nxt;
  logic [LW-1:0]  cell_val;

  // Best match found so far.
  logic [LW-1:0]  best_len_r, best_len_nxt;
  logic [LW-1:0]  best_row_r, best_row_nxt;
  logic [LW-1:0]  best_col_r, best_col_nxt;

  // Output register.
  logic           out_valid_r, out_valid_nxt;
  lcs_out_t       out_data_r, out_data_nxt;

  // Memory ports.
  logic           a_we, a_re, b_we, b_re, p_we, p_re;
  logic [AW-1:0]  a_waddr, a_raddr, b_waddr, b_raddr;
  logic [LW-1:0]  p_waddr, p_raddr;
  logic [7:0]     a_rdata, b_rdata;
  logic [LW-1:0]  p_rdata, p_wdata;

  logic           in_fire, slot_free, empty_match, last_byte;
  logic [LW-1:0]  emit_addr;
  logic [LW-1:0]  row_m1, col_m1;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign empty_match = (best_len_r == '0);
  assign last_byte   = empty_match || ((k_r + LW'(1)) == best_len_r);
  assign emit_addr   = best_row_r - best_len_r + k_r;

  // Table indexes are one-based; the string memories are zero-based.
  assign row_m1 = row_r - LW'(1);
  assign col_m1 = col_r - LW'(1);

  // A matching pair extends the run that ended on the diagonal neighbor.
  assign cell_val = (a_rdata == b_rdata) ? (diag_r + LW'(1)) : '0;

  lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN), .AW(AW)) u_first_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (in_data.symbol),
    .re    (a_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN), .AW(AW)) u_second_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (in_data.symbol),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  lcs_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1), .AW(LW)) u_row_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_data.opcode == OP_COMPUTE) begin
          if (first_len_r == '0 || second_len_r == '0) begin
            state_nxt = S_EMIT_PUT;
          end else begin
            state_nxt = S_ROW;
          end
        end
      end
      S_ROW: begin
        state_nxt = S_CELL;
      end
      S_CELL: begin
        if (col_r == second_len_r) begin
          state_nxt = (row_r == first_len_r) ? S_DRAIN : S_ROW;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_PUT;
      end
      S_EMIT_PUT: begin
        if (slot_free) begin
          state_nxt = last_byte ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath, memory control and output register loading.
  always_comb begin
    first_len_nxt  = first_len_r;
    second_len_nxt = second_len_r;
    overflow_nxt   = overflow_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    k_nxt          = k_r;
    cv_nxt         = 1'b0;
    cfirst_nxt     = cfirst_r;
    ccol_nxt       = ccol_r;
    crow_nxt       = crow_r;
    diag_nxt       = diag_r;
    best_len_nxt   = best_len_r;
    best_row_nxt   = best_row_r;
    best_col_nxt   = best_col_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    a_we    = 1'b0;
    a_waddr = first_len_r[AW-1:0];
    b_we    = 1'b0;
    b_waddr = second_len_r[AW-1:0];
    a_re    = 1'b0;
    a_raddr = emit_addr[AW-1:0];
    b_re    = 1'b0;
    b_raddr = '0;
    p_re    = 1'b0;
    p_raddr = col_r;
    p_we    = 1'b0;
    p_waddr = ccol_r;
    p_wdata = cell_val;

    // The cell fetched last cycle is written back and scanned for a new best.
    if (cv_r) begin
      p_we     = 1'b1;
      diag_nxt = cfirst_r ? '0 : p_rdata;
      if (cell_val > best_len_r) begin
        best_len_nxt = cell_val;
        best_row_nxt = crow_r;
        best_col_nxt = ccol_r;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.opcode)
            OP_APPEND_FIRST: begin
              if (first_len_r < LW'(MAX_LEN)) begin
                a_we          = 1'b1;
                first_len_nxt = first_len_r + LW'(1);
              end else begin
                overflow_nxt = 1'b1;
              end
            end
            OP_APPEND_SECOND: begin
              if (second_len_r < LW'(MAX_LEN)) begin
                b_we           = 1'b1;
                second_len_nxt = second_len_r + LW'(1);
              end else begin
                overflow_nxt = 1'b1;
              end
            end
            OP_COMPUTE: begin
              best_len_nxt = '0;
              best_row_nxt = '0;
              best_col_nxt = '0;
              row_nxt      = LW'(1);
              k_nxt        = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_ROW: begin
        // Fetch this row's byte of the first string; the diagonal starts at zero.
        a_re     = 1'b1;
        a_raddr  = row_m1[AW-1:0];
        col_nxt  = LW'(1);
        diag_nxt = '0;
      end
      S_CELL: begin
        // The row memory still holds the previous row; the first row reads as zero.
        b_re       = 1'b1;
        b_raddr    = col_m1[AW-1:0];
        p_re       = 1'b1;
        p_raddr    = col_r;
        cv_nxt     = 1'b1;
        cfirst_nxt = (row_r == LW'(1));
        ccol_nxt   = col_r;
        crow_nxt   = row_r;
        if (col_r == second_len_r) begin
          row_nxt = row_r + LW'(1);
        end else begin
          col_nxt = col_r + LW'(1);
        end
      end
      S_DRAIN: begin
      end
      S_EMIT_RD: begin
        a_re = 1'b1;
      end
      S_EMIT_PUT: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.out_symbol    = empty_match ? 8'd0 : a_rdata;
          out_data_nxt.match_length  = LCS_FIELD_W'(best_len_r);
          out_data_nxt.end_in_first  = LCS_FIELD_W'(best_row_r);
          out_data_nxt.end_in_second = LCS_FIELD_W'(best_col_r);
          out_data_nxt.is_empty      = empty_match;
          out_data_nxt.was_truncated = overflow_r;
          out_data_nxt.is_last       = last_byte;
          k_nxt                      = k_r + LW'(1);
          if (last_byte) begin
            first_len_nxt  = '0;
            second_len_nxt = '0;
            overflow_nxt   = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      first_len_r  <= '0;
      second_len_r <= '0;
      overflow_r   <= 1'b0;
      cv_r         <= 1'b0;
      best_len_r   <= '0;
      best_row_r   <= '0;
      best_col_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_len_r  <= first_len_nxt;
      second_len_r <= second_len_nxt;
      overflow_r   <= overflow_nxt;
      cv_r         <= cv_nxt;
      best_len_r   <= best_len_nxt;
      best_row_r   <= best_row_nxt;
      best_col_r   <= best_col_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    k_r        <= k_nxt;
    cfirst_r   <= cfirst_nxt;
    ccol_r     <= ccol_nxt;
    crow_r     <= crow_nxt;
    diag_r     <= diag_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> rtl/core/lcs_checker.sv
// Port-level checker for the longest common substring block, with its bind.
// Uses lcs_pkg; attaches to longest_common_substring_top.
module lcs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input lcs_pkg::lcs_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input lcs_pkg::lcs_out_t out_data
);

  import lcs_pkg::*;

  // A compute item always occupies the block for at least the next cycle.
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.opcode == OP_COMPUTE |=> in_stall)
    else $error("input not stalled after a compute item");

  // A no-match result is the only result of its compute.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> out_data.is_last)
    else $error("empty result not marked last");

  // A no-match result carries zero symbol, length and positions.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      out_data.out_symbol == 8'd0 && out_data.match_length == '0 &&
      out_data.end_in_first == '0 && out_data.end_in_second == '0)
    else $error("empty result with nonzero fields");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind longest_common_substring_top lcs_checker u_lcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> bench/lcs_scoreboard_pkg.sv
// Scoreboard for the longest common substring testbench: predicts each result item.
// Depends on lcs_pkg for the item types, opcodes and the string capacity.
`timescale 1ns / 1ps
package lcs_scoreboard_pkg;
  import lcs_pkg::*;

  class lcs_scoreboard;
    logic [7:0]  first_bytes [LCS_MAX_LEN];
    logic [7:0]  second_bytes [LCS_MAX_LEN];
    int          first_len;
    int          second_len;
    bit          dropped_append;
    lcs_out_t    match_bytes_q [$];
    int unsigned error_count;

    function new();
      first_len      = 0;
      second_len     = 0;
      dropped_append = 1'b0;
      error_count    = 0;
    endfunction

    function int unsigned pending();
      return match_bytes_q.size();
    endfunction

    // Called for every input item the block accepts.
    function void note_item(lcs_in_t item);
      case (item.opcode)
        OP_APPEND_FIRST: begin
          if (first_len < LCS_MAX_LEN) begin
            first_bytes[first_len] = item.symbol;
            first_len++;
          end else begin
            dropped_append = 1'b1;
          end
        end
        OP_APPEND_SECOND: begin
          if (second_len < LCS_MAX_LEN) begin
            second_bytes[second_len] = item.symbol;
            second_len++;
          end else begin
            dropped_append = 1'b1;
          end
        end
        OP_COMPUTE: find_longest_run();
        default: ;
      endcase
    endfunction

    // Diagonal-run table kept as a single row, rewritten from the high column down.
    // The first cell that beats all earlier ones in row-major order wins.
    function void find_longest_run();
      int       run_len [LCS_MAX_LEN+1];
      int       best_len;
      int       best_i;
      int       best_j;
      lcs_out_t res;
      foreach (run_len[j]) run_len[j] = 0;
      best_len = 0;
      best_i   = 0;
      best_j   = 0;
      for (int i = 1; i <= first_len; i++) begin
        for (int j = second_len; j >= 1; j--) begin
          run_len[j] = (first_bytes[i-1] == second_bytes[j-1]) ? run_len[j-1] + 1 : 0;
        end
        for (int j = 1; j <= second_len; j++) begin
          if (run_len[j] > best_len) begin
            best_len = run_len[j];
            best_i   = i;
            best_j   = j;
          end
        end
      end
      if (best_len == 0) begin
        res               = '0;
        res.is_empty      = 1'b1;
        res.was_truncated = dropped_append;
        res.is_last       = 1'b1;
        match_bytes_q.push_back(res);
      end else begin
        for (int k = 0; k < best_len; k++) begin
          res               = '0;
          res.out_symbol    = first_bytes[best_i - best_len + k];
          res.match_length  = LCS_FIELD_W'(best_len);
          res.end_in_first  = LCS_FIELD_W'(best_i);
          res.end_in_second = LCS_FIELD_W'(best_j);
          res.was_truncated = dropped_append;
          res.is_last       = (k == best_len - 1);
          match_bytes_q.push_back(res);
        end
      end
      first_len      = 0;
      second_len     = 0;
      dropped_append = 1'b0;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        error_count++;
      end
    endfunction

    // Called for every result item the testbench accepts.
    function void check_item(lcs_out_t got);
      lcs_out_t want;
      if (match_bytes_q.size() == 0) begin
        $error("result item arrived with nothing expected: %h", got);
        error_count++;
        return;
      end
      want = match_bytes_q.pop_front();
      compare_field("out_symbol", want.out_symbol, got.out_symbol);
      compare_field("match_length", 8'(want.match_length), 8'(got.match_length));
      compare_field("end_in_first", 8'(want.end_in_first), 8'(got.end_in_first));
      compare_field("end_in_second", 8'(want.end_in_second), 8'(got.end_in_second));
      compare_field("is_empty", 8'(want.is_empty), 8'(got.is_empty));
      compare_field("was_truncated", 8'(want.was_truncated), 8'(got.was_truncated));
      compare_field("is_last", 8'(want.is_last), 8'(got.is_last));
    endfunction
  endclass

endpackage

>>> bench/longest_common_substring_top_tb.sv
// Testbench for longest_common_substring_top: directed and random load/compute items.
// Depends on lcs_pkg and on lcs_scoreboard_pkg, which predicts and checks the results.
`timescale 1ns / 1ps
module longest_common_substring_top_tb;
  import lcs_pkg::*;
  import lcs_scoreboard_pkg::*;

  // Run length: a full 32 by 32 compute walks its whole table, and the
  // random part holds a few dozen computes, so this leaves a wide margin.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 64;
  localparam int ITEM_TARGET  = 480;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  lcs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lcs_out_t out_data;

  lcs_scoreboard sb;
  int            cycle_count = 0;
  int            items_sent = 0;
  int            hold_left = 0;
  bit            hold_request = 1'b0;
  // While calm is set neither side idles, so the block runs at full rate.
  bit            calm = 1'b0;

  longest_common_substring_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver side. The stall changes at the falling edge only. A hold-off
  // request makes it stall for a long stretch, counted here, so that the block
  // backs up and has to stall its own input.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 34);
    end
  end

  // Every result the receiver takes is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_item(out_data);
  end

  // Offers one item, with random idle cycles ahead of it, and returns once the
  // block has taken it. Valid stays high between back-to-back items.
  task automatic send_item(input lcs_opcode_t op, input logic [7:0] sym);
    lcs_in_t item;
    item.opcode = op;
    item.symbol = sym;
    while (!calm && $urandom_range(99) < 34) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(item);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // One load/compute sequence. Most are well formed: two strings drawn from a
  // narrow or a full byte alphabet, often with a shared piece planted in both,
  // loaded interleaved and then computed. Some run to full length, some go past
  // it so that appends are dropped, some leave one string empty, and a few are
  // plain noise of random opcodes.
  task automatic random_sequence();
    logic [7:0] first_str [40];
    logic [7:0] second_str [40];
    int len1, len2, shape, base, span, seg, src, dst, ia, ib;
    shape = $urandom_range(99);
    if (shape >= 92) begin
      repeat ($urandom_range(1, 6)) begin
        send_item(lcs_opcode_t'($urandom_range(3)), 8'($urandom));
      end
      return;
    end
    base = $urandom_range(255);
    span = ($urandom_range(3) == 0) ? 255 : $urandom_range(1, 3);
    if (shape < 8) begin
      len1 = LCS_MAX_LEN;
      len2 = LCS_MAX_LEN;
    end else if (shape < 18) begin
      len1 = $urandom_range(LCS_MAX_LEN);
      len2 = $urandom_range(LCS_MAX_LEN);
    end else begin
      len1 = $urandom_range(8);
      len2 = $urandom_range(8);
    end
    for (int k = 0; k < 40; k++) begin
      first_str[k]  = 8'(base + $urandom_range(span));
      second_str[k] = 8'(base + $urandom_range(span));
    end
    if (shape < 4) begin
      // Identical full strings: the match spans everything.
      for (int k = 0; k < 40; k++) second_str[k] = first_str[k];
    end else if (len1 > 0 && len2 > 0 && $urandom_range(1)) begin
      seg = $urandom_range(1, (len1 < len2) ? len1 : len2);
      src = $urandom_range(len1 - seg);
      dst = $urandom_range(len2 - seg);
      for (int k = 0; k < seg; k++) second_str[dst + k] = first_str[src + k];
    end
    // Appends past the capacity are dropped and flagged.
    if (len1 == LCS_MAX_LEN && $urandom_range(1)) len1 += $urandom_range(1, 3);
    if (len2 == LCS_MAX_LEN && $urandom_range(1)) len2 += $urandom_range(1, 3);
    ia = 0;
    ib = 0;
    while (ia < len1 || ib < len2) begin
      if ($urandom_range(19) == 0) begin
        send_item(OP_UNUSED, 8'($urandom));
      end else if (ib >= len2 || (ia < len1 && $urandom_range(1))) begin
        send_item(OP_APPEND_FIRST, first_str[ia]);
        ia++;
      end else begin
        send_item(OP_APPEND_SECOND, second_str[ib]);
        ib++;
      end
    end
    send_item(OP_COMPUTE, 8'($urandom));
  endtask

  initial begin
    int seq_count;
    sb = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Compute with both strings empty gives a single empty result.
    send_item(OP_COMPUTE, 8'h00);
    // The unused opcode is ignored.
    send_item(OP_UNUSED, 8'hFF);
    // Byte extremes and a tie between two one-byte runs: the earlier row wins.
    send_item(OP_APPEND_FIRST, 8'h00);
    send_item(OP_APPEND_FIRST, 8'hFF);
    send_item(OP_APPEND_SECOND, 8'hFF);
    send_item(OP_APPEND_SECOND, 8'h00);
    send_item(OP_COMPUTE, 8'hFF);
    // Only one of the two strings loaded: no match.
    send_item(OP_APPEND_FIRST, 8'hAA);
    send_item(OP_COMPUTE, 8'h55);
    send_item(OP_APPEND_SECOND, 8'h55);
    send_item(OP_COMPUTE, 8'hAA);
    // Both loaded but with no byte in common.
    send_item(OP_APPEND_FIRST, 8'h0F);
    send_item(OP_APPEND_SECOND, 8'hF0);
    send_item(OP_COMPUTE, 8'h00);
    // Repeated bytes, with an unused opcode between the loads.
    send_item(OP_APPEND_FIRST, 8'h5A);
    send_item(OP_APPEND_FIRST, 8'h5A);
    send_item(OP_UNUSED, 8'h00);
    send_item(OP_APPEND_FIRST, 8'h5A);
    send_item(OP_APPEND_SECOND, 8'h5A);
    send_item(OP_APPEND_SECOND, 8'h5A);
    send_item(OP_COMPUTE, 8'h00);

    seq_count = 0;
    while (items_sent < ITEM_TARGET) begin
      calm = (seq_count >= 12 && seq_count < 20);
      random_sequence();
      // Right after the fourth sequence (a compute, unless it was noise), hold the
      // receiver off for a long stretch while the sender keeps loading the next strings.
      if (seq_count == 3) hold_request = 1'b1;
      seq_count++;
    end
    calm = 1'b0;
    send_item(OP_COMPUTE, 8'($urandom));

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
